// ===== rtl/assert_macros.svh =====
// Assertion macros for the tap tempo RTL, included by tte_back.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define TTE_ASSERT(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed: label");
`define TTE_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: label");
`else
`define TTE_ASSERT(label, clk, rstn, expr)
`define TTE_ASSERT_IMPL(label, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/tte_pkg.sv =====
// Shared types and constants of the tap tempo estimator.
// No dependencies; imported by every module of the block.
package tte_pkg;

    localparam logic [15:0] TIMEOUT_RESET = 16'd2000;
    localparam logic [15:0] BPM_NUMERATOR = 16'd60000;
    localparam int          MEAN_W        = 16;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SUM,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MEAN,
        B_BPM,
        B_OUT
    } back_state_t;

endpackage

// ===== rtl/tte_fifo.sv =====
// Two-entry job queue between the front and back sections.
// Depends on tte_pkg only through the common import.
module tte_fifo
    import tte_pkg::*;
#(
    parameter int WIDTH = 21
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    logic [WIDTH-1:0] mem [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== rtl/tte_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on tte_pkg; used by the back section for both divisions.
module tte_div
    import tte_pkg::*;
#(
    parameter int WIDTH = 18
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [WIDTH-1:0] quotient
);

    localparam int CNT_W = $clog2(WIDTH);

    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;

    assign shifted  = {rem_reg, quo_reg[WIDTH-1]};
    assign diff     = shifted - {1'b0, dvs_reg};
    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= diff[WIDTH] ? shifted[WIDTH-1:0] : diff[WIDTH-1:0];
            quo_reg <= {quo_reg[WIDTH-2:0], ~diff[WIDTH]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WIDTH - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

endmodule

// ===== rtl/tte_front.sv =====
// Front section: accepts taps, checks the timeout, keeps the gap ring
// and sums the counted gaps into a job. Depends on tte_pkg.
module tte_front
    import tte_pkg::*;
#(
    parameter int HISTORY_DEPTH = 4
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic [31:0]                              s_tap_time_ms,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [15:0]                              cfg_data,
    output logic                                     push,
    output logic [MEAN_W+2*$clog2(HISTORY_DEPTH):0]  push_data,
    input  logic                                     full
);

    localparam int IW = $clog2(HISTORY_DEPTH);
    localparam int SW = MEAN_W + IW;

    front_state_t    state_reg, state_next;
    logic [15:0]     timeout_reg;
    logic [31:0]     last_time_reg;
    logic            last_valid_reg;
    logic [IW-1:0]   ws_reg;
    logic [IW-1:0]   ws_inc;
    logic [IW-1:0]   idx_reg;
    logic [15:0]     gap_mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] gap_ok_reg;
    logic [HISTORY_DEPTH-1:0] gap_ok_next;
    logic [SW-1:0]   sum_reg;
    logic [IW-1:0]   cnt_reg;
    logic            restart_reg;
    logic [31:0]     gap;
    logic            restart;
    logic            accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == F_IDLE);
    assign accept    = s_valid && s_ready;
    assign gap       = s_tap_time_ms - last_time_reg;
    assign restart   = last_valid_reg && (gap > {16'd0, timeout_reg});
    assign ws_inc    = (ws_reg == IW'(HISTORY_DEPTH - 1)) ? '0 : ws_reg + 1'b1;
    assign push_data = {restart_reg, cnt_reg, sum_reg};

    always_comb begin
        gap_ok_next = gap_ok_reg;
        // drop every gap on restart; the slot after the new tap spans
        // newest to oldest and is recomputed by the next tap
        if (restart) begin
            gap_ok_next = '0;
        end else begin
            gap_ok_next[ws_reg] = last_valid_reg && (gap != 32'd0);
            gap_ok_next[ws_inc] = 1'b0;
        end
    end

    always_comb begin
        state_next = state_reg;
        push       = 1'b0;
        case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    state_next = F_SUM;
                end
            end
            F_SUM: begin
                if (idx_reg == IW'(HISTORY_DEPTH - 1)) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!full) begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            gap_mem[ws_reg] <= gap[15:0];
            last_time_reg   <= s_tap_time_ms;
            restart_reg     <= restart;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg    <= TIMEOUT_RESET;
            last_valid_reg <= 1'b0;
            ws_reg         <= '0;
            gap_ok_reg     <= '0;
            idx_reg        <= '0;
            sum_reg        <= '0;
            cnt_reg        <= '0;
        end else begin
            if (cfg_valid) begin
                timeout_reg <= cfg_data;
            end
            if (accept) begin
                gap_ok_reg     <= gap_ok_next;
                last_valid_reg <= 1'b1;
                ws_reg         <= ws_inc;
                idx_reg        <= '0;
                sum_reg        <= '0;
                cnt_reg        <= '0;
            end else if (state_reg == F_SUM) begin
                if (gap_ok_reg[idx_reg]) begin
                    sum_reg <= sum_reg + SW'(gap_mem[idx_reg]);
                    cnt_reg <= cnt_reg + 1'b1;
                end
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

endmodule

// ===== rtl/tte_back.sv =====
// Back section: takes jobs from the queue, divides for mean and tempo
// on the shared divider and holds the result register. Depends on tte_pkg.
`include "assert_macros.svh"
module tte_back
    import tte_pkg::*;
#(
    parameter int HISTORY_DEPTH = 4
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     empty,
    input  logic [MEAN_W+2*$clog2(HISTORY_DEPTH):0]  pop_data,
    output logic                                     pop,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic [15:0]                              m_mean_interval_ms,
    output logic [15:0]                              m_tempo_bpm,
    output logic                                     m_has_tempo,
    output logic                                     m_restarted
);

    localparam int IW = $clog2(HISTORY_DEPTH);
    localparam int SW = MEAN_W + IW;

    back_state_t   state_reg, state_next;
    logic [SW-1:0] job_sum;
    logic [IW-1:0] job_cnt;
    logic          job_restart;
    logic          div_start;
    logic [SW-1:0] div_dividend;
    logic [SW-1:0] div_divisor;
    logic          div_busy;
    logic          div_done;
    logic [SW-1:0] div_quo;
    logic [15:0]   mean_reg;
    logic [15:0]   bpm_reg;
    logic          has_reg;
    logic          rst_reg;
    logic          load_out;
    logic          m_valid_reg;

    assign job_sum     = pop_data[SW-1:0];
    assign job_cnt     = pop_data[SW+IW-1:SW];
    assign job_restart = pop_data[SW+IW];
    assign m_valid     = m_valid_reg;

    tte_div #(
        .WIDTH(SW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(div_dividend),
        .divisor (div_divisor),
        .busy    (div_busy),
        .done    (div_done),
        .quotient(div_quo)
    );

    always_comb begin
        state_next   = state_reg;
        pop          = 1'b0;
        div_start    = 1'b0;
        div_dividend = job_sum;
        div_divisor  = SW'(job_cnt);
        load_out     = 1'b0;
        case (state_reg)
            B_IDLE: begin
                if (!empty) begin
                    pop = 1'b1;
                    if (job_restart || job_cnt == '0) begin
                        state_next = B_OUT;
                    end else begin
                        div_start  = 1'b1;
                        state_next = B_MEAN;
                    end
                end
            end
            B_MEAN: begin
                if (div_done) begin
                    div_start    = 1'b1;
                    div_dividend = SW'(BPM_NUMERATOR);
                    div_divisor  = SW'(div_quo[15:0]);
                    state_next   = B_BPM;
                end
            end
            B_BPM: begin
                if (div_done) begin
                    state_next = B_OUT;
                end
            end
            B_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            mean_reg <= '0;
            bpm_reg  <= '0;
            has_reg  <= 1'b0;
            rst_reg  <= job_restart;
        end
        if (state_reg == B_MEAN && div_done) begin
            mean_reg <= div_quo[15:0];
        end
        if (state_reg == B_BPM && div_done) begin
            bpm_reg <= div_quo[15:0];
            has_reg <= 1'b1;
        end
        if (load_out) begin
            m_mean_interval_ms <= mean_reg;
            m_tempo_bpm        <= bpm_reg;
            m_has_tempo        <= has_reg;
            m_restarted        <= rst_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    `TTE_ASSERT_IMPL(a_div_start_idle, aclk, aresetn, div_start, !div_busy)
    `TTE_ASSERT_IMPL(a_div_done_state, aclk, aresetn, div_done,
        state_reg == B_MEAN || state_reg == B_BPM)
    `TTE_ASSERT_IMPL(a_tempo_sane, aclk, aresetn, m_valid_reg && m_has_tempo,
        m_mean_interval_ms != 16'd0 && !m_restarted)

endmodule

// ===== rtl/tap_tempo_estimator_core.sv =====
// Tap tempo estimator: mean tap interval and tempo from tap timestamps.
// Instantiates tte_front, tte_fifo and tte_back; depends on tte_pkg.
//
// Channels: s_valid/s_ready carry one tap timestamp (ms, 32 bit, wrapping).
// m_valid/m_ready carry one result per tap: mean interval, tempo in
// beats per minute, has_tempo and restarted. cfg_valid/cfg_ready write the
// restart timeout in ms; cfg_ready is always high, write only while idle.
// The front takes each accepted tap and sums the stored gaps of all
// HISTORY_DEPTH slots; the back then runs the shared 16+log2(HISTORY_DEPTH)
// bit divider twice, one quotient bit per cycle, and loads the output
// register. A tap that restarts history or has no gap skips the divider.
// The front accepts the next tap once it has pushed its job, while the
// back may still be dividing for the earlier one.
// A two-entry queue parts front and back; when the receiver stalls the
// result holds in the output register, the back waits and then the front.
// Reset clears tap history, the write slot and all valid marks and loads
// the default 2000 ms timeout.
module tap_tempo_estimator_core
    import tte_pkg::*;
#(
    parameter int HISTORY_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_tap_time_ms,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_mean_interval_ms,
    output logic [15:0] m_tempo_bpm,
    output logic        m_has_tempo,
    output logic        m_restarted,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int JW = MEAN_W + 2 * $clog2(HISTORY_DEPTH) + 1;

    logic          push;
    logic [JW-1:0] push_data;
    logic          full;
    logic          pop;
    logic [JW-1:0] pop_data;
    logic          empty;

    tte_front #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_tap_time_ms(s_tap_time_ms),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .push         (push),
        .push_data    (push_data),
        .full         (full)
    );

    tte_fifo #(
        .WIDTH(JW)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(push_data),
        .full     (full),
        .pop      (pop),
        .pop_data (pop_data),
        .empty    (empty)
    );

    tte_back #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .empty             (empty),
        .pop_data          (pop_data),
        .pop               (pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_mean_interval_ms(m_mean_interval_ms),
        .m_tempo_bpm       (m_tempo_bpm),
        .m_has_tempo       (m_has_tempo),
        .m_restarted       (m_restarted)
    );

endmodule
